// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the bubble babble encoder modules. They sample
// on clk_i and are disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// File: hdl/bbe_pkg.sv
// ----------------------------------------------------------------------------
// bbe_pkg
// Types, character tables and small arithmetic helpers of the bubble babble
// encoder.
// ----------------------------------------------------------------------------
package bbe_pkg;

  localparam int unsigned CHAR_W          = 7;
  localparam int unsigned NUM_SLOTS       = 7;
  localparam int unsigned CNT_W           = $clog2(NUM_SLOTS + 1);
  localparam int unsigned SEED_W          = 6;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [SEED_W-1:0] seed_t;

  localparam seed_t SEED_INIT = 6'd1;

  localparam char_t CH_X    = 7'h78;
  localparam char_t CH_DASH = 7'h2d;

  localparam char_t VOWEL_TAB [6] = '{7'h61, 7'h65, 7'h69, 7'h6f, 7'h75, 7'h79};
  localparam char_t CONS_TAB [16] = '{
    7'h62, 7'h63, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6b, 7'h6c,
    7'h6d, 7'h6e, 7'h70, 7'h72, 7'h73, 7'h74, 7'h76, 7'h7a
  };

  // one queued job: the characters caused by one item
  typedef struct packed {
    char_t [NUM_SLOTS-1:0] chars;
    logic [CNT_W-1:0]      count;
    logic                  msg_end;
  } job_t;

  // exact for any 6-bit value
  function automatic logic [3:0] div6(logic [5:0] x);
    logic [11:0] p;
    p = 12'(x) * 12'd43;
    return p[11:8];
  endfunction

  function automatic logic [2:0] mod6(logic [5:0] x);
    logic [3:0] q;
    logic [5:0] r;
    q = div6(x);
    r = x - 6'(q) * 6'd6;
    return r[2:0];
  endfunction

  // exact for values below 2305
  function automatic seed_t mod36(logic [11:0] x);
    logic [20:0] p;
    logic [5:0]  q;
    logic [11:0] r;
    p = 21'(x) * 21'd455;
    q = p[19:14];
    r = x - 12'(q) * 12'd36;
    if (r >= 12'd36) begin
      r = r - 12'd36;
    end
    return r[5:0];
  endfunction

  function automatic char_t vowel_char(logic [5:0] x);
    return VOWEL_TAB[mod6(x)];
  endfunction

  function automatic char_t cons_char(logic [3:0] x);
    return CONS_TAB[x];
  endfunction

endpackage

// File: hdl/bbe_in_if.sv
// ----------------------------------------------------------------------------
// bbe_in_if
// Message byte channel of the bubble babble encoder.
// ----------------------------------------------------------------------------
interface bbe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       last;

  modport source (output valid, output data_byte, output has_byte, output last,
                  input ready);
  modport sink (input valid, input data_byte, input has_byte, input last,
                output ready);
endinterface

// File: hdl/bbe_out_if.sv
// ----------------------------------------------------------------------------
// bbe_out_if
// Character channel of the bubble babble encoder.
// ----------------------------------------------------------------------------
interface bbe_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       run_end;
  logic       message_end;

  modport source (output valid, output out_char, output run_end,
                  output message_end, input ready);
  modport sink (input valid, input out_char, input run_end, input message_end,
                output ready);
endinterface

// File: hdl/bubble_babble_encoder.sv
// ----------------------------------------------------------------------------
// bubble_babble_encoder
// Streams message bytes in and bubble babble characters out.
//
//   channel  dir  beat
//   in_i     in   data_byte, has_byte, last
//   out_o    out  out_char, run_end, message_end
//
// One character leaves per cycle while out_o is ready; a byte gives three characters,
// plus the leading and closing groups, so a byte's beat gives three to seven characters.
// A beat enters in the cycle after the previous one while the job queue has
// room; the output register sets the pace.
// A beat passes the decode register, the job queue and the output register. Reset
// is asynchronous, loads the initial seed and clears the pair state and the queue.
// ----------------------------------------------------------------------------
module bubble_babble_encoder #(
  parameter int unsigned QueueDepth = bbe_pkg::QUEUE_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bbe_in_if.sink    in_i,
  bbe_out_if.source out_o
);
  import bbe_pkg::*;

  job_t front_job, back_job;
  logic front_valid, front_ready, back_valid, back_ready;

  bbe_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .job_o       (front_job),
    .job_valid_o (front_valid),
    .job_ready_i (front_ready)
  );

  bbe_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (front_job),
    .in_valid_i  (front_valid),
    .in_ready_o  (front_ready),
    .out_data_o  (back_job),
    .out_valid_o (back_valid),
    .out_ready_i (back_ready)
  );

  bbe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (back_job),
    .job_valid_i (back_valid),
    .job_ready_o (back_ready),
    .out_o       (out_o)
  );

endmodule

// File: hdl/bbe_front.sv
// ----------------------------------------------------------------------------
// bbe_front
// Takes message beats, keeps the seed and pair state, and builds one job of
// up to seven characters per beat that carries a byte or closes a message.
// ----------------------------------------------------------------------------
module bbe_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  bbe_in_if.sink        in_i,
  output bbe_pkg::job_t job_o,
  output logic          job_valid_o,
  input  logic          job_ready_i
);
  import bbe_pkg::*;

  // message state
  seed_t      seed_q, seed_d;
  logic [7:0] held_q, held_d;
  logic       odd_q, odd_d;
  logic       started_q, started_d;

  // decode stage
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  logic       s1_has_q, s1_last_q, s1_first_q, s1_odd_q;
  seed_t      s1_seed_q, s1_seed_new_q;
  logic [2:0] s1_seed_hi_q;

  logic        accept, active;
  logic [11:0] seed_sum;
  seed_t       seed_new;
  logic [3:0]  seed_hi_full;

  seed_t            close_seed;
  logic [3:0]       close_hi;
  logic [CNT_W-1:0] n;

  assign in_i.ready  = !s1_valid_q || job_ready_i;
  assign accept      = in_i.valid && in_i.ready;
  assign active      = accept && (in_i.has_byte || in_i.last);
  assign seed_sum    = 12'(seed_q) * 12'd5 + 12'(held_q) * 12'd7 + 12'(in_i.data_byte);
  assign seed_new    = mod36(seed_sum);
  assign seed_hi_full = div6(seed_q);

  always_comb begin
    seed_d    = seed_q;
    held_d    = held_q;
    odd_d     = odd_q;
    started_d = started_q;
    if (active) begin
      started_d = 1'b1;
      if (in_i.has_byte) begin
        odd_d = !odd_q;
        if (!odd_q) begin
          held_d = in_i.data_byte;
        end else begin
          seed_d = seed_new;
        end
      end
      if (in_i.last) begin
        seed_d    = SEED_INIT;
        held_d    = '0;
        odd_d     = 1'b0;
        started_d = 1'b0;
      end
    end
  end

  assign s1_valid_d = in_i.ready ? active : s1_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q     <= SEED_INIT;
      held_q     <= '0;
      odd_q      <= 1'b0;
      started_q  <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      seed_q     <= seed_d;
      held_q     <= held_d;
      odd_q      <= odd_d;
      started_q  <= started_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (active) begin
      s1_byte_q     <= in_i.data_byte;
      s1_has_q      <= in_i.has_byte;
      s1_last_q     <= in_i.last;
      s1_first_q    <= !started_q;
      s1_odd_q      <= odd_q;
      s1_seed_q     <= seed_q;
      s1_seed_hi_q  <= seed_hi_full[2:0];
      s1_seed_new_q <= seed_new;
    end
  end

  // character assembly
  assign close_seed = (s1_has_q && s1_odd_q) ? s1_seed_new_q : s1_seed_q;
  assign close_hi   = div6(close_seed);

  always_comb begin
    job_o = '0;
    n     = '0;
    if (s1_first_q) begin
      job_o.chars[n] = CH_X;
      n = n + 1'b1;
    end
    if (s1_has_q) begin
      if (!s1_odd_q) begin
        job_o.chars[n] = vowel_char(6'(s1_byte_q[7:6]) + s1_seed_q);
        n = n + 1'b1;
        job_o.chars[n] = cons_char(s1_byte_q[5:2]);
        n = n + 1'b1;
        job_o.chars[n] = vowel_char(6'(s1_byte_q[1:0]) + 6'(s1_seed_hi_q));
        n = n + 1'b1;
      end else begin
        job_o.chars[n] = cons_char(s1_byte_q[7:4]);
        n = n + 1'b1;
        job_o.chars[n] = CH_DASH;
        n = n + 1'b1;
        job_o.chars[n] = cons_char(s1_byte_q[3:0]);
        n = n + 1'b1;
      end
    end
    if (s1_last_q) begin
      if (s1_has_q == s1_odd_q) begin
        job_o.chars[n] = vowel_char(close_seed);
        n = n + 1'b1;
        job_o.chars[n] = CH_X;
        n = n + 1'b1;
        job_o.chars[n] = VOWEL_TAB[close_hi[2:0]];
        n = n + 1'b1;
      end
      job_o.chars[n] = CH_X;
      n = n + 1'b1;
      job_o.msg_end = 1'b1;
    end
    job_o.count = n;
  end

  assign job_valid_o = s1_valid_q;

endmodule

// File: hdl/bbe_queue.sv
// ----------------------------------------------------------------------------
// bbe_queue
// Small job queue between the front and back parts.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bbe_queue #(
  parameter int unsigned Depth = bbe_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  bbe_pkg::job_t in_data_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output bbe_pkg::job_t out_data_o,
  output logic          out_valid_o,
  input  logic          out_ready_i
);
  import bbe_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            slots_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign in_ready_o  = (count_q != CntW'(Depth));
  assign out_valid_o = (count_q != '0);
  assign out_data_o  = slots_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q] <= in_data_i;
    end
  end

  `ASSERT_ALWAYS(q_empty_ptrs, (count_q == '0) |-> (rd_ptr_q == wr_ptr_q), "queue empty with pointers apart")
  `ASSERT_ALWAYS(q_full_ptrs, (count_q == CntW'(Depth)) |-> (rd_ptr_q == wr_ptr_q), "queue full with pointers apart")

endmodule

// File: hdl/bbe_back.sv
// ----------------------------------------------------------------------------
// bbe_back
// Walks the characters of the head job and drives them one per beat through
// an output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bbe_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  bbe_pkg::job_t job_i,
  input  logic          job_valid_i,
  output logic          job_ready_o,
  bbe_out_if.source     out_o
);
  import bbe_pkg::*;

  logic [CNT_W-1:0] idx_q, idx_d;
  logic             out_valid_q, out_valid_d;
  char_t            char_q;
  logic             run_end_q, msg_end_q;
  logic             load, last_char;

  assign load        = !out_valid_q || out_o.ready;
  assign last_char   = (idx_q == job_i.count - 1'b1);
  assign job_ready_o = load && job_valid_i && last_char;

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = job_valid_i;
      if (job_valid_i) begin
        idx_d = last_char ? '0 : idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && job_valid_i) begin
      char_q    <= job_i.chars[idx_q];
      run_end_q <= last_char;
      msg_end_q <= last_char && job_i.msg_end;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.out_char    = char_q;
  assign out_o.run_end     = run_end_q;
  assign out_o.message_end = msg_end_q;

  `ASSERT_ALWAYS(idx_in_job, job_valid_i |-> (idx_q < job_i.count), "character index past job")
  `ASSERT_ALWAYS(msg_end_is_run_end, (out_valid_q && msg_end_q) |-> run_end_q, "message end not on run end")

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bubble babble encoder. A directed table (empty
// message, the classic digit string, byte extremes, ignored beats, closing
// with and without a byte) is followed by random messages of random length.
// Each character is compared with the row's text if set, else an in-bench encoder model.
// Sender and receiver stall at random in two phases of different pressure, then none in a third.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bbe_pkg::*;

  typedef struct packed {
    char_t ch;
    logic  run_end;
    logic  msg_end;
  } bb_char_t;

  typedef struct {
    logic [7:0] data;
    logic       has;
    logic       last;
    string      text;
  } stim_row_t;

  localparam int NUM_ROWS = 25;
  localparam int RAND_BEATS_PER_PHASE = 160;

  stim_row_t dir_rows [NUM_ROWS] = '{
    '{8'h00, 1'b0, 1'b0, ""},
    '{8'h00, 1'b0, 1'b1, "xexax"},
    '{8'h31, 1'b1, 1'b0, "xese"},
    '{8'h32, 1'b1, 1'b0, "f-d"},
    '{8'h33, 1'b1, 1'b0, "iso"},
    '{8'h34, 1'b1, 1'b0, "f-g"},
    '{8'h35, 1'b1, 1'b0, "ytu"},
    '{8'h36, 1'b1, 1'b0, "f-k"},
    '{8'h37, 1'b1, 1'b0, "ato"},
    '{8'h38, 1'b1, 1'b0, "f-m"},
    '{8'h39, 1'b1, 1'b0, "ovi"},
    '{8'h30, 1'b1, 1'b1, "f-baxux"},
    '{8'hff, 1'b1, 1'b1, "xuzox"},
    '{8'h00, 1'b1, 1'b1, "xebax"},
    '{8'h00, 1'b1, 1'b0, ""},
    '{8'hff, 1'b1, 1'b1, ""},
    '{8'hff, 1'b1, 1'b0, ""},
    '{8'hff, 1'b0, 1'b0, ""},
    '{8'h00, 1'b1, 1'b0, ""},
    '{8'h00, 1'b0, 1'b1, ""},
    '{8'ha5, 1'b1, 1'b0, ""},
    '{8'h5a, 1'b1, 1'b0, ""},
    '{8'hc3, 1'b1, 1'b0, ""},
    '{8'h7e, 1'b0, 1'b1, ""},
    '{8'h3c, 1'b1, 1'b1, ""}
  };

  logic clk_i;
  logic rst_ni;

  bbe_in_if  in_if ();
  bbe_out_if out_if ();

  bubble_babble_encoder dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  string vowel_set = "aeiouy";
  string cons_set  = "bcdfghklmnprstvz";

  // encoder state
  logic [5:0] chk_seed;
  logic [7:0] pair_byte;
  logic       odd_pos;
  logic       msg_open;

  bb_char_t pending_chars [$];
  bb_char_t got_char;
  bb_char_t want_char;

  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned beat_count;
  int unsigned byte_count;
  int unsigned msg_count;
  int unsigned char_count;
  int unsigned fail_count;

  function automatic string encode_beat(logic [7:0] b, logic has, logic lst);
    string s;
    int    sd;
    s  = "";
    sd = int'(chk_seed);
    if (!has && !lst) begin
      return s;
    end
    if (!msg_open) begin
      s        = "x";
      msg_open = 1'b1;
    end
    if (has) begin
      if (!odd_pos) begin
        s = $sformatf("%s%c%c%c", s, vowel_set[(int'(b[7:6]) + sd) % 6],
                      cons_set[int'(b[5:2])], vowel_set[(int'(b[1:0]) + sd / 6) % 6]);
        pair_byte = b;
        odd_pos   = 1'b1;
      end else begin
        s = $sformatf("%s%c-%c", s, cons_set[int'(b[7:4])], cons_set[int'(b[3:0])]);
        sd        = (sd * 5 + int'(pair_byte) * 7 + int'(b)) % 36;
        chk_seed  = 6'(sd);
        odd_pos   = 1'b0;
      end
    end
    if (lst) begin
      if (!odd_pos) begin
        s = $sformatf("%sx%s", {s, string'(vowel_set[sd % 6])}, string'(vowel_set[sd / 6]));
      end
      s         = {s, "x"};
      chk_seed  = 6'd1;
      pair_byte = 8'h00;
      odd_pos   = 1'b0;
      msg_open  = 1'b0;
    end
    return s;
  endfunction

  // entered and left at a falling edge
  task automatic send_beat(input logic [7:0] data, input logic has, input logic lst,
                           input string text);
    string    s;
    bb_char_t c;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.data_byte <= data;
    in_if.has_byte  <= has;
    in_if.last      <= lst;
    do @(posedge clk_i); while (!in_if.ready);
    s = encode_beat(data, has, lst);
    if (text.len() > 0) begin
      s = text;
    end
    if (has || lst) begin
      beat_count++;
    end
    if (has) begin
      byte_count++;
    end
    if (lst) begin
      msg_count++;
    end
    for (int i = 0; i < s.len(); i++) begin
      c.ch      = char_t'(s[i]);
      c.run_end = (i == s.len() - 1);
      c.msg_end = (i == s.len() - 1) && lst;
      pending_chars.push_back(c);
    end
    @(negedge clk_i);
  endtask

  task automatic send_message();
    int   len;
    logic close_on_byte;
    len           = ($urandom_range(9) == 0) ? $urandom_range(40, 12) : $urandom_range(8);
    close_on_byte = $urandom_range(1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(15) == 0) begin
        send_beat(8'($urandom_range(255)), 1'b0, 1'b0, "");
      end
      send_beat(8'($urandom_range(255)), 1'b1, (i == len - 1) && close_on_byte, "");
    end
    if (len == 0 || !close_on_byte) begin
      send_beat(8'($urandom_range(255)), 1'b0, 1'b1, "");
    end
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      got_char = '{out_if.out_char, out_if.run_end, out_if.message_end};
      char_count++;
      if (pending_chars.size() == 0) begin
        fail_count++;
        $display("%0t: expected no char, got %c run_end %b message_end %b", $realtime,
                 got_char.ch, got_char.run_end, got_char.msg_end);
      end else begin
        want_char = pending_chars.pop_front();
        if (got_char != want_char) begin
          fail_count++;
          $display("%0t: expected char %c run_end %b message_end %b, got %c %b %b",
                   $realtime, want_char.ch, want_char.run_end, want_char.msg_end,
                   got_char.ch, got_char.run_end, got_char.msg_end);
        end
      end
    end
  end

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

  initial begin
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.data_byte = 8'h00;
    in_if.has_byte  = 1'b0;
    in_if.last      = 1'b0;
    tx_idle_pct     = 32;
    rx_idle_pct     = 55;
    beat_count      = 0;
    byte_count      = 0;
    msg_count       = 0;
    char_count      = 0;
    fail_count      = 0;
    chk_seed        = 6'd1;
    pair_byte       = 8'h00;
    odd_pos         = 1'b0;
    msg_open        = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int r = 0; r < NUM_ROWS; r++) begin
      send_beat(dir_rows[r].data, dir_rows[r].has, dir_rows[r].last, dir_rows[r].text);
    end

    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = (ph == 0) ? 32 : (ph == 1) ? 55 : 0;
      rx_idle_pct = (ph == 0) ? 55 : (ph == 1) ? 32 : 0;
      while (beat_count < NUM_ROWS + RAND_BEATS_PER_PHASE * (ph + 1)) begin
        send_message();
      end
      // hold the sender until the character stream runs dry
      drain();
      @(negedge clk_i);
    end

    drain();
    repeat (20) @(posedge clk_i);
    $display("tb: sent %0d beats (%0d bytes) in %0d messages", beat_count, byte_count,
             msg_count);
    $display("tb: checked %0d characters under three stall mixes", char_count);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
